FILE: rtl/mbrhr_pkg.sv
// Constants and types for the read-holding-registers responder.
package mbrhr_pkg;

  localparam int STORE_DEPTH_DEF = 8;

  localparam int FC_READ_HOLDING = 8'h03;
  localparam int MIN_REQUEST_LEN = 12;
  localparam int HEADER_LEN      = 9;
  localparam int PDU_FIXED_LEN   = 3;

  // Request byte positions that are kept
  localparam logic [3:0] RXP_TID_HI   = 4'd0;
  localparam logic [3:0] RXP_TID_LO   = 4'd1;
  localparam logic [3:0] RXP_UNIT     = 4'd6;
  localparam logic [3:0] RXP_FUNC     = 4'd7;
  localparam logic [3:0] RXP_START_HI = 4'd8;
  localparam logic [3:0] RXP_START_LO = 4'd9;
  localparam logic [3:0] RXP_COUNT_HI = 4'd10;
  localparam logic [3:0] RXP_COUNT_LO = 4'd11;

  // Response header byte positions
  localparam int TXP_TID_HI = 0;
  localparam int TXP_TID_LO = 1;
  localparam int TXP_LEN_LO = 5;
  localparam int TXP_UNIT   = 6;
  localparam int TXP_FUNC   = 7;
  localparam int TXP_BCOUNT = 8;

  localparam logic CMD_RX_BYTE   = 1'b0;
  localparam logic CMD_REG_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } mbrhr_state_t;

endpackage

FILE: rtl/modbus_read_holding_responder_top.sv
// Read-holding-registers responder: header capture, register store and response streaming.
//
// Each accepted request either writes one holding register (reg_index beyond the store is
// ignored) or delivers one received request byte. A new request is taken every cycle while
// no response is being produced. When the last byte of a segment of at least 12 bytes with
// function 0x03 arrives, the block sizes the frame in S_CALC and then streams 9 + 2n
// response bytes at one per cycle while out_ready allows (n = requested count clipped to
// the store), holding off input until the final byte sits in the output register. Register
// bytes come from the store's single read port, addressed one byte ahead so that reading
// never pauses the stream. The store reads as zero after reset through per-entry valid
// bits; no clearing pass is needed.
module modbus_read_holding_responder_top #(
  parameter int STORE_DEPTH = mbrhr_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_segment_end,
  input  logic [2:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);
  import mbrhr_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int NW = $clog2(STORE_DEPTH + 1);
  localparam int TW = $clog2(HEADER_LEN + 2 * STORE_DEPTH + 1);

  mbrhr_state_t state_r, state_nxt;

  logic [3:0]  pos_r, pos_nxt, pos_inc;
  logic [15:0] tid_r;
  logic [7:0]  unit_r;
  logic [7:0]  func_r, func_next;
  logic [15:0] start_r;
  logic [15:0] count_r;

  logic [NW-1:0] n_r;
  logic [NW-1:0] rd_base_r;
  logic [TW-1:0] k_r, k_nxt;

  logic          out_valid_r;
  logic [7:0]    out_tx_byte_r;
  logic          out_last_r;

  logic [15:0]   store_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [15:0]   mem_q_r;
  logic          vld_q_r;

  logic          in_acc;
  logic          rx_acc;
  logic          wr_en;
  logic [7:0]    widx_full;
  logic [AW-1:0] wr_idx;
  logic          load;
  logic          frame_go;

  logic [15:0]   rem;
  logic [15:0]   n_calc;
  logic [TW-1:0] total_m1;
  logic [TW-1:0] k_off;
  logic [TW-1:0] k_nxt_off;
  logic [NW:0]   raddr_sum;
  logic [AW-1:0] rd_idx;
  logic [15:0]   data16;
  logic [7:0]    nbytes;
  logic [7:0]    len_lo;
  logic [7:0]    tx_byte;
  logic          tx_last;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign rx_acc   = in_acc && (in_command == CMD_RX_BYTE);

  // Register write decode
  assign widx_full = 8'(in_reg_index);
  assign wr_idx    = widx_full[AW-1:0];
  assign wr_en     = in_acc && (in_command == CMD_REG_WRITE) &&
                     (widx_full < 8'(STORE_DEPTH));

  // Header tracking
  assign pos_inc   = (pos_r < 4'(MIN_REQUEST_LEN)) ? pos_r + 4'd1 : pos_r;
  assign func_next = (pos_r == RXP_FUNC) ? in_rx_byte : func_r;
  assign frame_go  = rx_acc && in_segment_end && (pos_inc >= 4'(MIN_REQUEST_LEN)) &&
                     (func_next == 8'(FC_READ_HOLDING));

  always_comb begin
    pos_nxt = pos_r;
    if (rx_acc) begin
      pos_nxt = in_segment_end ? 4'd0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc) begin
      case (pos_r)
        RXP_TID_HI:   tid_r[15:8]   <= in_rx_byte;
        RXP_TID_LO:   tid_r[7:0]    <= in_rx_byte;
        RXP_UNIT:     unit_r        <= in_rx_byte;
        RXP_FUNC:     func_r        <= in_rx_byte;
        RXP_START_HI: start_r[15:8] <= in_rx_byte;
        RXP_START_LO: start_r[7:0]  <= in_rx_byte;
        RXP_COUNT_HI: count_r[15:8] <= in_rx_byte;
        RXP_COUNT_LO: count_r[7:0]  <= in_rx_byte;
        default: ;
      endcase
    end
    if (!rst_n) begin
      tid_r   <= '0;
      unit_r  <= '0;
      func_r  <= '0;
      start_r <= '0;
      count_r <= '0;
    end
  end

  // Frame sizing: clip the count to the store, zero when the start lies beyond it
  assign rem    = 16'(STORE_DEPTH) - start_r;
  always_comb begin
    n_calc = 16'd0;
    if (start_r < 16'(STORE_DEPTH)) begin
      n_calc = (count_r > rem) ? rem : count_r;
    end
  end

  assign total_m1 = TW'(HEADER_LEN - 1) + TW'({n_r, 1'b0});
  assign nbytes   = 8'({n_r, 1'b0});
  assign len_lo   = 8'(PDU_FIXED_LEN) + nbytes;
  assign load     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (frame_go) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_EMIT;
        k_nxt     = '0;
      end
      S_EMIT: begin
        if (load) begin
          k_nxt = k_r + TW'(1);
          if (k_r == total_m1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      n_r       <= NW'(n_calc);
      rd_base_r <= start_r[NW-1:0];
    end
  end

  // Read the entry for the byte after the one being loaded; clamp addresses outside the store
  assign k_nxt_off = k_nxt - TW'(HEADER_LEN);
  assign raddr_sum = (NW+1)'(rd_base_r) + (NW+1)'(k_nxt_off >> 1);
  assign rd_idx    = (raddr_sum < (NW+1)'(STORE_DEPTH)) ? raddr_sum[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_idx] <= in_reg_value;
    end
    mem_q_r <= store_mem[rd_idx];
    vld_q_r <= vld_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  assign data16 = vld_q_r ? mem_q_r : 16'd0;
  assign k_off  = k_r - TW'(HEADER_LEN);

  always_comb begin
    tx_byte = 8'h00;
    if (k_r >= TW'(HEADER_LEN)) begin
      tx_byte = k_off[0] ? data16[7:0] : data16[15:8];
    end else begin
      case (k_r)
        TW'(TXP_TID_HI): tx_byte = tid_r[15:8];
        TW'(TXP_TID_LO): tx_byte = tid_r[7:0];
        TW'(TXP_LEN_LO): tx_byte = len_lo;
        TW'(TXP_UNIT):   tx_byte = unit_r;
        TW'(TXP_FUNC):   tx_byte = 8'(FC_READ_HOLDING);
        TW'(TXP_BCOUNT): tx_byte = nbytes;
        default:         tx_byte = 8'h00;
      endcase
    end
  end

  assign tx_last = (k_r == total_m1);

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tx_byte_r <= tx_byte;
      out_last_r    <= tx_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_byte_r;
  assign out_last    = out_last_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 4'(MIN_REQUEST_LEN))
    else $error("byte position beyond request header");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (k_r <= total_m1))
    else $error("response byte index beyond frame");

  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (n_r <= NW'(STORE_DEPTH)))
    else $error("register count beyond store");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && tx_last) |=> (state_r == S_IDLE))
    else $error("frame continued after last byte");

endmodule

FILE: tb/modbus_read_holding_responder_top_tb.sv
// Self-checking testbench for the Modbus read-holding-registers responder.
`timescale 1ns / 100ps

module modbus_read_holding_responder_top_tb;
  import mbrhr_pkg::*;

  localparam int STORE_DEPTH = STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_SEG     = 24;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_RX_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_segment_end = 1'b0;
  logic [2:0]  in_reg_index = 3'd0;
  logic [15:0] in_reg_value = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  // Mirror of the responder state
  logic [15:0] hold_regs [STORE_DEPTH] = '{default: 16'h0000};
  logic [3:0]  rx_pos = 4'd0;
  logic [15:0] txn_id = 16'h0000;
  logic [7:0]  unit_reg = 8'h00;
  logic [7:0]  func_reg = 8'h00;
  logic [15:0] req_start = 16'h0000;
  logic [15:0] req_count = 16'h0000;

  frame_byte_t resp_q [$];
  frame_byte_t got_want;

  bit idle_on = 1'b1;
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int segments_sent = 0;
  int frames_expected = 0;
  int bytes_checked = 0;

  modbus_read_holding_responder_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_rx_byte(in_rx_byte),
    .in_segment_end(in_segment_end),
    .in_reg_index(in_reg_index),
    .in_reg_value(in_reg_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tx_byte(out_tx_byte),
    .out_last(out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count, resp_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic is_last);
    frame_byte_t fb;
    fb.tx_byte = b;
    fb.last    = is_last;
    resp_q.push_back(fb);
  endfunction

  // Build the whole response frame from the captured header and the store
  function automatic void queue_response();
    int unsigned n;
    int unsigned first;
    int unsigned cnt;
    int unsigned nbytes;
    int unsigned len;
    logic [15:0] v;
    n      = 0;
    first  = req_start;
    cnt    = req_count;
    if (first < STORE_DEPTH) begin
      n = cnt;
      if (first + cnt > STORE_DEPTH) n = STORE_DEPTH - first;
    end
    nbytes = 2 * n;
    len    = PDU_FIXED_LEN + nbytes;
    push_byte(txn_id[15:8], 1'b0);
    push_byte(txn_id[7:0], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(len[15:8], 1'b0);
    push_byte(len[7:0], 1'b0);
    push_byte(unit_reg, 1'b0);
    push_byte(8'(FC_READ_HOLDING), 1'b0);
    push_byte(nbytes[7:0], n == 0);
    for (int unsigned i = 0; i < n; i++) begin
      v = hold_regs[first + i];
      push_byte(v[15:8], 1'b0);
      push_byte(v[7:0], i == n - 1);
    end
    frames_expected++;
  endfunction

  function automatic void predict_request(input logic cmd, input logic [7:0] b,
                                          input logic seg_end, input logic [2:0] idx,
                                          input logic [15:0] val);
    int unsigned pos;
    if (cmd == CMD_REG_WRITE) begin
      if (idx < STORE_DEPTH) hold_regs[idx] = val;
      return;
    end
    case (rx_pos)
      RXP_TID_HI:   txn_id[15:8] = b;
      RXP_TID_LO:   txn_id[7:0] = b;
      RXP_UNIT:     unit_reg = b;
      RXP_FUNC:     func_reg = b;
      RXP_START_HI: req_start[15:8] = b;
      RXP_START_LO: req_start[7:0] = b;
      RXP_COUNT_HI: req_count[15:8] = b;
      RXP_COUNT_LO: req_count[7:0] = b;
      default: ;
    endcase
    pos = rx_pos;
    if (pos < MIN_REQUEST_LEN) pos++;
    if (seg_end) begin
      if (pos >= MIN_REQUEST_LEN && func_reg == FC_READ_HOLDING) queue_response();
      pos = 0;
    end
    rx_pos = pos[3:0];
  endfunction

  function automatic void log_mismatch(input string what, input frame_byte_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
               what, cycle_count, want.tx_byte, want.last, out_tx_byte, out_last);
  endfunction

  // Check each response byte against the oldest pending one, and drive the stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (resp_q.size() == 0) begin
        log_mismatch("no byte pending", '0);
      end else begin
        got_want = resp_q.pop_front();
        bytes_checked++;
        if (out_tx_byte !== got_want.tx_byte || out_last !== got_want.last)
          log_mismatch("wrong byte", got_want);
      end
    end
    out_ready <= idle_on ? ($urandom_range(99) >= 8) : 1'b1;
  end

  // Offer one request and hold it until taken
  task automatic send_request(input logic cmd, input logic [7:0] b, input logic seg_end,
                              input logic [2:0] idx, input logic [15:0] val);
    int gap;
    gap = 0;
    if (idle_on) while ($urandom_range(99) < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_rx_byte     <= b;
    in_segment_end <= seg_end;
    in_reg_index   <= idx;
    in_reg_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, b, seg_end, idx, val);
    items_sent++;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
    send_request(CMD_REG_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), idx, val);
    writes_sent++;
  endtask

  // Send one segment; register writes may slip in between its bytes
  task automatic send_segment(input logic [15:0] tid, input logic [7:0] unit_id,
                              input logic [7:0] func, input logic [15:0] first,
                              input logic [15:0] cnt, input int seg_len,
                              input bit mix_writes);
    logic [7:0] seg [MAX_SEG];
    foreach (seg[i]) seg[i] = 8'($urandom_range(255));
    seg[0]  = tid[15:8];
    seg[1]  = tid[7:0];
    seg[6]  = unit_id;
    seg[7]  = func;
    seg[8]  = first[15:8];
    seg[9]  = first[7:0];
    seg[10] = cnt[15:8];
    seg[11] = cnt[7:0];
    for (int i = 0; i < seg_len; i++) begin
      if (mix_writes && i > 0 && $urandom_range(99) < 10)
        write_register(3'($urandom_range(STORE_DEPTH - 1)), 16'($urandom_range(65535)));
      send_request(CMD_RX_BYTE, seg[i], i == seg_len - 1, 3'($urandom_range(7)),
                   16'($urandom_range(65535)));
    end
    segments_sent++;
  endtask

  task automatic random_segment(input int seg_len);
    logic [7:0]  func;
    logic [15:0] first;
    logic [15:0] cnt;
    func  = ($urandom_range(99) < 88) ? 8'(FC_READ_HOLDING) : 8'($urandom_range(255));
    if ($urandom_range(99) < 85)
      first = 16'($urandom_range(STORE_DEPTH - 1));
    else if ($urandom_range(1))
      first = 16'($urandom_range(2 * STORE_DEPTH, STORE_DEPTH));
    else
      first = 16'($urandom_range(65535));
    cnt = ($urandom_range(99) < 85) ? 16'($urandom_range(STORE_DEPTH + 2)) :
                                      16'($urandom_range(65535));
    send_segment(16'($urandom_range(65535)), 8'($urandom_range(255)), func, first, cnt,
                 seg_len, 1'b1);
  endtask

  task automatic test_register_writes();
    write_register(3'd0, 16'hFFFF);
    write_register(3'd1, 16'h0000);
    write_register(3'd2, 16'h8000);
    write_register(3'd3, 16'h0001);
    write_register(3'd4, 16'h7FFF);
    write_register(3'd5, 16'hAAAA);
    write_register(3'd6, 16'h5555);
    write_register(3'd7, 16'($urandom_range(65535)));
  endtask

  // Whole store in one frame: the longest response
  task automatic test_full_read();
    send_segment(16'hFFFF, 8'hFF, 8'(FC_READ_HOLDING), 16'h0000, 16'(STORE_DEPTH), 12, 1'b0);
  endtask

  task automatic test_short_segment();
    send_segment(16'h1234, 8'h11, 8'(FC_READ_HOLDING), 16'h0000, 16'h0001, 5, 1'b0);
  endtask

  task automatic test_clipped_reads();
    // start just past the store, then far past it
    send_segment(16'h0000, 8'h00, 8'(FC_READ_HOLDING), 16'(STORE_DEPTH), 16'h0001, 12, 1'b0);
    send_segment(16'hA5A5, 8'h5A, 8'(FC_READ_HOLDING), 16'hFFFF, 16'hFFFF, 12, 1'b0);
    // count running off the end, and a huge count
    send_segment(16'h0102, 8'h01, 8'(FC_READ_HOLDING), 16'(STORE_DEPTH - 3), 16'd10, 12,
                 1'b0);
    send_segment(16'h8001, 8'h80, 8'(FC_READ_HOLDING), 16'h0001, 16'hFFFF, 12, 1'b1);
    send_segment(16'h7FFE, 8'h7F, 8'(FC_READ_HOLDING), 16'h0002, 16'h0000, 12, 1'b0);
    send_segment(16'h4242, 8'h42, 8'h04, 16'h0000, 16'h0004, 12, 1'b0);
    // long segment: position must hold at the limit well past its 4-bit range
    send_segment(16'h3C3C, 8'hC3, 8'(FC_READ_HOLDING), 16'(STORE_DEPTH - 1), 16'h0001, 20,
                 1'b1);
    send_segment(16'h0F0F, 8'hF0, 8'(FC_READ_HOLDING), 16'h0000, 16'h0002, 11, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int base;
    int sel;
    base = items_sent;
    while (items_sent - base < n_items) begin
      sel = $urandom_range(99);
      if (sel < 65)
        random_segment(($urandom_range(99) < 80) ? 12 : $urandom_range(MAX_SEG, 13));
      else if (sel < 75)
        random_segment($urandom_range(11, 1));
      else if (sel < 92)
        write_register(3'($urandom_range(STORE_DEPTH - 1)), 16'($urandom_range(65535)));
      else
        send_request(CMD_RX_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     3'($urandom_range(7)), 16'($urandom_range(65535)));
    end
  endtask

  task automatic test_no_idle_stream(input int n_items);
    int base;
    base = items_sent;
    idle_on = 1'b0;
    while (items_sent - base < n_items) begin
      if ($urandom_range(3) == 0)
        write_register(3'($urandom_range(STORE_DEPTH - 1)), 16'($urandom_range(65535)));
      random_segment(12);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_register_writes();
    test_full_read();
    test_short_segment();
    test_clipped_reads();
    test_random_traffic(80);
    test_no_idle_stream(36);
    test_random_traffic(10);
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d requests: %0d register writes and %0d segments.",
             items_sent, writes_sent, segments_sent);
    $display("Checked %0d response bytes over %0d frames, %0d mismatches.",
             bytes_checked, frames_expected, mismatches);
    if (mismatches == 0 && resp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
